FILE: hw/rtl/ccem_pkg.sv
// ----------------------------------------------------------------------------
// ccem_pkg
// Types and constants shared by the calendar clock event matcher modules.
// ----------------------------------------------------------------------------
package ccem_pkg;

  localparam int unsigned DEFAULT_TABLE_SLOTS = 16;

  localparam int unsigned MinutesPerHour = 60;
  localparam int unsigned HoursPerDay    = 24;
  localparam int unsigned DaysShortMonth = 28;
  localparam int unsigned DaysMidMonth   = 30;
  localparam int unsigned DaysLongMonth  = 31;
  localparam int unsigned MonthsPerYear  = 12;
  localparam int unsigned LastYear       = 9999;

  localparam logic [13:0] RESET_YEAR = 14'd2024;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;

  typedef struct packed {
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } time_t;

  localparam int unsigned TIME_W = $bits(time_t);

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_ADDED   = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_TICK    = 2'd2,
    STAT_RESTART = 2'd3
  } status_e;

  typedef struct packed {
    logic advance;
    logic restart;
  } cal_ctrl_t;

endpackage

FILE: hw/rtl/ccem_alarm_mem.sv
// ----------------------------------------------------------------------------
// ccem_alarm_mem
// Alarm table storage: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module ccem_alarm_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 34,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/ccem_calendar.sv
// ----------------------------------------------------------------------------
// ccem_calendar
// Minute-resolution calendar clock with restart and one-minute advance.
// ----------------------------------------------------------------------------
module ccem_calendar
  import ccem_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cal_ctrl_t   ctrl_i,
  input  logic [13:0] start_year_i,
  output time_t       now_o
);

  time_t now_q, now_d;
  logic [6:0] min_sum;
  logic [5:0] hour_sum;
  logic [5:0] day_sum;
  logic [4:0] month_sum;
  logic       thirty_day;
  logic       month_end;

  assign min_sum   = {1'b0, now_q.minute} + 7'd1;
  assign hour_sum  = {1'b0, now_q.hour} + 6'd1;
  assign day_sum   = {1'b0, now_q.day} + 6'd1;
  assign month_sum = {1'b0, now_q.month} + 5'd1;

  assign thirty_day = (now_q.month == MONTH_APR) || (now_q.month == MONTH_JUN) ||
                      (now_q.month == MONTH_SEP) || (now_q.month == MONTH_NOV);
  assign month_end  = ((now_q.month == MONTH_FEB) && (day_sum > 6'(DaysShortMonth))) ||
                      (thirty_day && (day_sum > 6'(DaysMidMonth))) ||
                      (day_sum > 6'(DaysLongMonth));

  always_comb begin
    now_d = now_q;
    if (ctrl_i.restart) begin
      now_d.minute = '0;
      now_d.hour   = '0;
      now_d.day    = 5'd1;
      now_d.month  = MONTH_JAN;
      now_d.year   = start_year_i;
    end else if (ctrl_i.advance) begin
      if (min_sum < 7'(MinutesPerHour)) begin
        now_d.minute = min_sum[5:0];
      end else begin
        now_d.minute = '0;
        if (hour_sum < 6'(HoursPerDay)) begin
          now_d.hour = hour_sum[4:0];
        end else begin
          now_d.hour = '0;
          if (!month_end) begin
            now_d.day = day_sum[4:0];
          end else begin
            now_d.day = 5'd1;
            if (month_sum <= 5'(MonthsPerYear)) begin
              now_d.month = month_sum[3:0];
            end else begin
              now_d.month = MONTH_JAN;
              if (now_q.year >= 14'(LastYear)) begin
                now_d.year = '0;
              end else begin
                now_d.year = now_q.year + 14'd1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '{minute: 6'd0, hour: 5'd0, year: RESET_YEAR, month: MONTH_JAN, day: 5'd1};
    end else begin
      now_q <= now_d;
    end
  end

  assign now_o = now_q;

endmodule

FILE: hw/rtl/calendar_clock_event_matcher.sv
// ----------------------------------------------------------------------------
// calendar_clock_event_matcher
// Calendar clock with an alarm table that is matched against the time on tick.
// ----------------------------------------------------------------------------
// An add or restart item and a tick on an empty table are taken while idle,
// and their result shows on the next cycle with done_o high; busy stays low,
// so such items may follow every cycle. A tick with N stored alarms scans the
// table through its single read port, one slot per cycle, with busy high
// until its result shows. Results are never held back, so a receiver must
// take each result in the cycle that done_o marks.
module calendar_clock_event_matcher
  import ccem_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = DEFAULT_TABLE_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [13:0] cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [4:0]  alarm_day_i,
  input  logic [3:0]  alarm_month_i,
  input  logic [13:0] alarm_year_i,
  input  logic [4:0]  alarm_hour_i,
  input  logic [5:0]  alarm_minute_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [4:0]  now_day_o,
  output logic [3:0]  now_month_o,
  output logic [13:0] now_year_o,
  output logic [4:0]  now_hour_o,
  output logic [5:0]  now_minute_o,
  output logic [15:0] match_mask_o,
  output logic [3:0]  slot_used_o
);

  localparam int unsigned IdxW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(TABLE_SLOTS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                 state_q;
  logic [CntW-1:0]        entry_count_q;
  logic [IdxW-1:0]        cmp_idx_q;
  logic [TABLE_SLOTS-1:0] acc_q;
  logic [TABLE_SLOTS-1:0] acc_d;
  logic [13:0]            start_year_q;
  logic                   done_q;
  status_e                status_q;
  time_t                  out_time_q;
  logic [15:0]            mask_q;
  logic [3:0]             slot_q;

  time_t         cal_now;
  time_t         new_alarm;
  time_t         restart_time;
  cal_ctrl_t     cal_ctrl;
  logic [TIME_W-1:0] rd_data;
  logic          accept;
  logic          table_full;
  logic          table_empty;
  logic          last_slot;
  logic          hit;
  logic          wr_en;
  logic          rd_en;
  logic [IdxW-1:0] rd_addr;

  assign busy        = (state_q == ST_SCAN);
  assign accept      = start && !busy;
  assign table_full  = (entry_count_q == CntW'(TABLE_SLOTS));
  assign table_empty = (entry_count_q == '0);
  assign last_slot   = ((CntW'(cmp_idx_q) + CntW'(1)) == entry_count_q);
  assign hit         = (time_t'(rd_data) == cal_now);

  assign new_alarm = '{minute: alarm_minute_i, hour: alarm_hour_i, year: alarm_year_i,
                       month: alarm_month_i, day: alarm_day_i};
  assign restart_time = '{minute: 6'd0, hour: 5'd0, year: start_year_q,
                          month: MONTH_JAN, day: 5'd1};

  assign wr_en   = accept && (opcode_e'(opcode_i) == OP_ADD) && !table_full;
  assign rd_en   = (accept && (opcode_e'(opcode_i) == OP_TICK) && !table_empty) ||
                   (busy && !last_slot);
  assign rd_addr = busy ? (cmp_idx_q + IdxW'(1)) : '0;

  assign cal_ctrl.restart = accept && (opcode_e'(opcode_i) == OP_RESTART);
  assign cal_ctrl.advance = (accept && (opcode_e'(opcode_i) == OP_TICK) && table_empty) ||
                            (busy && last_slot);

  always_comb begin
    acc_d            = acc_q;
    acc_d[cmp_idx_q] = hit;
  end

  ccem_alarm_mem #(
    .DEPTH (TABLE_SLOTS),
    .WIDTH (TIME_W)
  ) u_alarm_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (entry_count_q[IdxW-1:0]),
    .wr_data_i (new_alarm),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ccem_calendar u_calendar (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (cal_ctrl),
    .start_year_i (start_year_q),
    .now_o        (cal_now)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      entry_count_q <= '0;
      cmp_idx_q     <= '0;
      acc_q         <= '0;
      start_year_q  <= RESET_YEAR;
      done_q        <= 1'b0;
      status_q      <= STAT_ADDED;
      out_time_q    <= '0;
      mask_q        <= '0;
      slot_q        <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        start_year_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (opcode_e'(opcode_i))
              OP_ADD: begin
                done_q     <= 1'b1;
                out_time_q <= cal_now;
                mask_q     <= '0;
                if (table_full) begin
                  status_q <= STAT_FULL;
                  slot_q   <= '0;
                end else begin
                  status_q      <= STAT_ADDED;
                  slot_q        <= 4'(entry_count_q[IdxW-1:0]);
                  entry_count_q <= entry_count_q + CntW'(1);
                end
              end
              OP_TICK: begin
                if (table_empty) begin
                  done_q     <= 1'b1;
                  status_q   <= STAT_TICK;
                  out_time_q <= cal_now;
                  mask_q     <= '0;
                  slot_q     <= '0;
                end else begin
                  state_q   <= ST_SCAN;
                  cmp_idx_q <= '0;
                  acc_q     <= '0;
                end
              end
              OP_RESTART: begin
                done_q     <= 1'b1;
                status_q   <= STAT_RESTART;
                out_time_q <= restart_time;
                mask_q     <= '0;
                slot_q     <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          acc_q <= acc_d;
          if (last_slot) begin
            state_q    <= ST_IDLE;
            done_q     <= 1'b1;
            status_q   <= STAT_TICK;
            out_time_q <= cal_now;
            mask_q     <= 16'(acc_d);
            slot_q     <= '0;
          end else begin
            cmp_idx_q <= cmp_idx_q + IdxW'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign now_day_o    = out_time_q.day;
  assign now_month_o  = out_time_q.month;
  assign now_year_o   = out_time_q.year;
  assign now_hour_o   = out_time_q.hour;
  assign now_minute_o = out_time_q.minute;
  assign match_mask_o = mask_q;
  assign slot_used_o  = slot_q;

endmodule

FILE: hw/rtl/ccem_checker.sv
// ----------------------------------------------------------------------------
// ccem_checker
// Port-level checks on the calendar clock event matcher, bound to the top.
// ----------------------------------------------------------------------------
module ccem_checker
  import ccem_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  opcode_i,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [4:0]  now_day_o,
  input logic [3:0]  now_month_o,
  input logic [4:0]  now_hour_o,
  input logic [5:0]  now_minute_o,
  input logic [15:0] match_mask_o,
  input logic [3:0]  slot_used_o
);

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while a scan is still running");

  a_busy_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && (opcode_i == OP_TICK)))
    else $error("scan started without a tick item");

  a_restart_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == OP_RESTART)) |=>
      (done_o && (status_o == STAT_RESTART) && (now_day_o == 5'd1) &&
       (now_month_o == MONTH_JAN) && (now_hour_o == 5'd0) && (now_minute_o == 6'd0)))
    else $error("restart item did not give the reset time");

  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ((status_o == STAT_FULL) || (status_o == STAT_RESTART))) |->
      ((match_mask_o == 16'd0) && (slot_used_o == 4'd0)))
    else $error("mask or slot set on a result that carries neither");

endmodule

bind calendar_clock_event_matcher ccem_checker u_ccem_checker (.*);

FILE: test/calendar_match_checker.sv
// ----------------------------------------------------------------------------
// calendar_match_checker
// Watches the item and result ports of the calendar clock event matcher,
// keeps its own calendar clock and alarm table, and compares every result
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module calendar_match_checker
  import ccem_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = DEFAULT_TABLE_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [13:0] cfg_wdata_i,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  opcode_i,
  input  logic [4:0]  alarm_day_i,
  input  logic [3:0]  alarm_month_i,
  input  logic [13:0] alarm_year_i,
  input  logic [4:0]  alarm_hour_i,
  input  logic [5:0]  alarm_minute_i,
  input  logic        done_i,
  input  logic [1:0]  status_i,
  input  logic [4:0]  now_day_i,
  input  logic [3:0]  now_month_i,
  input  logic [13:0] now_year_i,
  input  logic [4:0]  now_hour_i,
  input  logic [5:0]  now_minute_i,
  input  logic [15:0] match_mask_i,
  input  logic [3:0]  slot_used_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o
);

  typedef struct packed {
    status_e     status;
    time_t       now;
    logic [15:0] mask;
    logic [3:0]  slot;
  } calendar_result_t;

  time_t            clock_now;
  time_t            alarm_slots [TABLE_SLOTS];
  int unsigned      alarms_stored;
  logic [13:0]      restart_year;
  calendar_result_t result_q [$];
  calendar_result_t want;
  logic             gives_result;
  int unsigned      mismatches = 0;
  int unsigned      outstanding = 0;

  assign mismatches_o  = mismatches;
  assign outstanding_o = outstanding;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] expected);
    if (got !== expected) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, expected));
    end
  endtask

  function automatic int unsigned month_length(logic [3:0] month);
    case (month)
      MONTH_FEB: return DaysShortMonth;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return DaysMidMonth;
      default: return DaysLongMonth;
    endcase
  endfunction

  function automatic time_t next_minute(time_t t);
    time_t n;
    n = t;
    if (t.minute < MinutesPerHour - 1) begin
      n.minute = t.minute + 6'd1;
    end else begin
      n.minute = 6'd0;
      if (t.hour < HoursPerDay - 1) begin
        n.hour = t.hour + 5'd1;
      end else begin
        n.hour = 5'd0;
        if (t.day < month_length(t.month)) begin
          n.day = t.day + 5'd1;
        end else begin
          n.day = 5'd1;
          if (t.month < MonthsPerYear) begin
            n.month = t.month + 4'd1;
          end else begin
            n.month = MONTH_JAN;
            n.year  = (t.year >= LastYear) ? 14'd0 : t.year + 14'd1;
          end
        end
      end
    end
    return n;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_now     = '{minute: 6'd0, hour: 5'd0, year: RESET_YEAR,
                        month: MONTH_JAN, day: 5'd1};
      alarms_stored = 0;
      restart_year  = RESET_YEAR;
      result_q.delete();
      outstanding   = 0;
    end else begin
      if (done_i) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("result with status %0d and no item waiting",
                                    status_i));
        end else begin
          want = result_q.pop_front();
          check_field("status", status_i, want.status);
          check_field("now_day", now_day_i, want.now.day);
          check_field("now_month", now_month_i, want.now.month);
          check_field("now_year", now_year_i, want.now.year);
          check_field("now_hour", now_hour_i, want.now.hour);
          check_field("now_minute", now_minute_i, want.now.minute);
          check_field("match_mask", match_mask_i, want.mask);
          check_field("slot_used", slot_used_i, want.slot);
        end
      end

      if (cfg_we_i) begin
        restart_year = cfg_wdata_i;
      end

      if (start_i && !busy_i) begin
        gives_result = 1'b1;
        want.now     = clock_now;
        want.mask    = '0;
        want.slot    = '0;
        want.status  = STAT_TICK;
        case (opcode_i)
          OP_ADD: begin
            if (alarms_stored < TABLE_SLOTS) begin
              alarm_slots[alarms_stored] = '{minute: alarm_minute_i, hour: alarm_hour_i,
                                             year: alarm_year_i, month: alarm_month_i,
                                             day: alarm_day_i};
              want.slot   = alarms_stored[3:0];
              want.status = STAT_ADDED;
              alarms_stored++;
            end else begin
              want.status = STAT_FULL;
            end
          end
          OP_TICK: begin
            for (int i = 0; i < alarms_stored; i++) begin
              if (alarm_slots[i] == clock_now) want.mask[i] = 1'b1;
            end
            clock_now   = next_minute(clock_now);
            want.status = STAT_TICK;
          end
          OP_RESTART: begin
            clock_now   = '{minute: 6'd0, hour: 5'd0, year: restart_year,
                            month: MONTH_JAN, day: 5'd1};
            want.now    = clock_now;
            want.status = STAT_RESTART;
          end
          default: begin
            gives_result = 1'b0;
          end
        endcase
        if (gives_result) result_q.push_back(want);
      end

      outstanding = result_q.size();
    end
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for the calendar clock event matcher. A directed part covers
// every operation, two hours of ticks through the hour rollover, field extremes
// and a full alarm table; random phases with different start years and sender
// idling follow. Results are checked by calendar_match_checker.
// ----------------------------------------------------------------------------
module tb
  import ccem_pkg::*;
();

  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned HOUR_TICKS   = 2 * MinutesPerHour;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 117;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [13:0] cfg_wdata_i    = '0;
  logic        start          = 1'b0;
  logic        busy;
  logic [1:0]  opcode_i       = OP_TICK;
  logic [4:0]  alarm_day_i    = '0;
  logic [3:0]  alarm_month_i  = '0;
  logic [13:0] alarm_year_i   = '0;
  logic [4:0]  alarm_hour_i   = '0;
  logic [5:0]  alarm_minute_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [4:0]  now_day_o;
  logic [3:0]  now_month_o;
  logic [13:0] now_year_o;
  logic [4:0]  now_hour_o;
  logic [5:0]  now_minute_o;
  logic [15:0] match_mask_o;
  logic [3:0]  slot_used_o;
  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned idle_pct = 0;

  calendar_clock_event_matcher uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .alarm_day_i   (alarm_day_i),
    .alarm_month_i (alarm_month_i),
    .alarm_year_i  (alarm_year_i),
    .alarm_hour_i  (alarm_hour_i),
    .alarm_minute_i(alarm_minute_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .now_day_o     (now_day_o),
    .now_month_o   (now_month_o),
    .now_year_o    (now_year_o),
    .now_hour_o    (now_hour_o),
    .now_minute_o  (now_minute_o),
    .match_mask_o  (match_mask_o),
    .slot_used_o   (slot_used_o)
  );

  calendar_match_checker match_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start),
    .busy_i        (busy),
    .opcode_i      (opcode_i),
    .alarm_day_i   (alarm_day_i),
    .alarm_month_i (alarm_month_i),
    .alarm_year_i  (alarm_year_i),
    .alarm_hour_i  (alarm_hour_i),
    .alarm_minute_i(alarm_minute_i),
    .done_i        (done_o),
    .status_i      (status_o),
    .now_day_i     (now_day_o),
    .now_month_i   (now_month_o),
    .now_year_i    (now_year_o),
    .now_hour_i    (now_hour_o),
    .now_minute_i  (now_minute_o),
    .match_mask_i  (match_mask_o),
    .slot_used_i   (slot_used_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic time_t any_alarm_time();
    time_t t;
    t = time_t'(TIME_W'({$urandom, $urandom}));
    return t;
  endfunction

  // Alarms close to a restart, so that a few ticks after a restart hit them.
  function automatic time_t alarm_at(logic [13:0] year, logic [5:0] minute);
    return '{minute: minute, hour: 5'd0, year: year, month: MONTH_JAN, day: 5'd1};
  endfunction

  function automatic logic [13:0] pick_year();
    case ($urandom_range(3))
      0: return 14'd0;
      1: return RESET_YEAR;
      2: return LastYear[13:0];
      default: return 14'h3fff;
    endcase
  endfunction

  task automatic send_item(input logic [1:0] op, input time_t alarm);
    opcode_i       <= op;
    alarm_day_i    <= alarm.day;
    alarm_month_i  <= alarm.month;
    alarm_year_i   <= alarm.year;
    alarm_hour_i   <= alarm.hour;
    alarm_minute_i <= alarm.minute;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_start_year(input logic [13:0] year);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= year;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int unsigned phase_idle [PHASES] = '{0, 87, 30, 0, 87, 30};
    logic [13:0] phase_year [PHASES];
    int unsigned roll;

    phase_year = '{14'd0, 14'h3fff, LastYear[13:0], RESET_YEAR, 14'd0, 14'd1};
    phase_year[4] = 14'($urandom_range(16383));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_item(OP_TICK, any_alarm_time());
    send_item(OP_UNUSED, any_alarm_time());
    send_item(OP_RESTART, any_alarm_time());

    // Two hours of ticks on the empty table pass the hour rollover twice.
    load_start_year(14'd0);
    send_item(OP_RESTART, any_alarm_time());
    for (int n = 0; n < HOUR_TICKS; n++) send_item(OP_TICK, any_alarm_time());
    send_item(OP_RESTART, any_alarm_time());

    send_item(OP_ADD, '{minute: 6'h3f, hour: 5'h1f, year: 14'h3fff, month: 4'hf,
                        day: 5'h1f});
    send_item(OP_ADD, '0);
    send_item(OP_ADD, alarm_at(14'd0, 6'd0));
    send_item(OP_ADD, alarm_at(14'd0, 6'd1));
    send_item(OP_ADD, alarm_at(14'd0, 6'd1));
    send_item(OP_TICK, any_alarm_time());
    send_item(OP_TICK, any_alarm_time());
    for (int k = 5; k < DEFAULT_TABLE_SLOTS; k++) begin
      send_item(OP_ADD, alarm_at(pick_year(), 6'($urandom_range(5))));
    end
    send_item(OP_ADD, any_alarm_time());
    send_item(OP_RESTART, any_alarm_time());
    send_item(OP_TICK, any_alarm_time());

    for (int p = 0; p < PHASES; p++) begin
      load_start_year(phase_year[p]);
      idle_pct = phase_idle[p];
      send_item(OP_RESTART, any_alarm_time());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 7) begin
          send_item(OP_ADD, alarm_at(pick_year(), 6'($urandom_range(5))));
        end else if (roll < 10) begin
          send_item(OP_ADD, any_alarm_time());
        end else if (roll < 70) begin
          send_item(OP_TICK, any_alarm_time());
        end else if (roll < 92) begin
          send_item(OP_RESTART, any_alarm_time());
        end else begin
          send_item(OP_UNUSED, any_alarm_time());
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("calendar_clock_event_matcher regression: pass");
    end else begin
      $display("calendar_clock_event_matcher regression: fail");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("calendar_clock_event_matcher regression: fail");
    $finish;
  end

endmodule
